>>> rtl/sbm_pkg.sv
`default_nettype none

package sbm_pkg;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_PRG_BANKS         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRG_ROM_PRESENT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRG_RAM_PRESENT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRG_RAM_SIZE_LOG2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHR_ROM_PRESENT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHR_RAM_PRESENT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHR_SIZE_BYTES    = 3'd6;

    // access kinds
    localparam logic [1:0] KIND_CPU_RD = 2'd0;
    localparam logic [1:0] KIND_CPU_WR = 2'd1;
    localparam logic [1:0] KIND_PPU_RD = 2'd2;
    localparam logic [1:0] KIND_PPU_WR = 2'd3;

    // serial load destinations, bus address bits 14:13
    localparam logic [1:0] DEST_CONTROL  = 2'd0;
    localparam logic [1:0] DEST_CHR_LOW  = 2'd1;
    localparam logic [1:0] DEST_CHR_HIGH = 2'd2;
    localparam logic [1:0] DEST_PRG      = 2'd3;

    // PRG banking modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

    localparam logic [4:0]  SHIFT_RESET     = 5'h10;
    localparam logic [4:0]  CONTROL_RESET   = 5'h0C;
    localparam logic [2:0]  LOAD_LAST       = 3'd4;
    localparam logic [15:0] RAM_WINDOW_BASE = 16'h6000;
    localparam logic [15:0] ROM_BASE        = 16'h8000;
    localparam logic [3:0]  RAM_LOG2_MAX    = 4'd13;

    typedef enum logic [2:0] {
        TGT_NONE       = 3'd0,
        TGT_PRG_ROM_RD = 3'd1,
        TGT_PRG_RAM_RD = 3'd2,
        TGT_PRG_RAM_WR = 3'd3,
        TGT_CHR_ROM_RD = 3'd4,
        TGT_CHR_RAM_RD = 3'd5,
        TGT_CHR_RAM_WR = 3'd6,
        TGT_REG_WR     = 3'd7
    } target_t;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_PRG_ROM = 3'd1,
        CLS_RAM_RD  = 3'd2,
        CLS_RAM_WR  = 3'd3,
        CLS_REG_WR  = 3'd4,
        CLS_CHR_RD  = 3'd5,
        CLS_CHR_WR  = 3'd6
    } access_cls_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [21:0] mem_address;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  prg_banks;
        logic        prg_rom_present;
        logic        prg_ram_present;
        logic [3:0]  prg_ram_size_log2;
        logic        chr_rom_present;
        logic        chr_ram_present;
        logic [17:0] chr_size_bytes;
    } cfg_t;

    typedef struct packed {
        access_cls_t cls;
        logic [15:0] bus_address;
        logic [12:0] ram_offset;
        logic        load_reset;
        logic        load_bit;
    } queue_item_t;

endpackage

`default_nettype wire

>>> rtl/sbm_front.sv
`default_nettype none

module sbm_front (
    input  sbm_pkg::req_t        req,
    input  sbm_pkg::cfg_t        cfg,
    output sbm_pkg::queue_item_t item
);
    import sbm_pkg::*;

    logic        in_rom_area;
    logic        ram_window;
    logic [3:0]  ram_log2;
    logic [12:0] ram_mask;

    assign in_rom_area = (req.bus_address >= ROM_BASE);
    assign ram_window  = (req.bus_address >= RAM_WINDOW_BASE) && !in_rom_area;
    assign ram_log2    = (cfg.prg_ram_size_log2 > RAM_LOG2_MAX) ? RAM_LOG2_MAX
                                                                : cfg.prg_ram_size_log2;

    always_comb
    begin
        for (int i = 0; i < 13; i++)
        begin
            ram_mask[i] = (4'(i) < ram_log2);
        end
    end

    always_comb
    begin
        item.cls         = CLS_NONE;
        item.bus_address = req.bus_address;
        // inside the window the offset from the base is just the low 13 bits
        item.ram_offset  = req.bus_address[12:0] & ram_mask;
        item.load_reset  = req.write_byte[7];
        item.load_bit    = req.write_byte[0];
        case (req.kind)
            KIND_CPU_RD:
            begin
                if (cfg.prg_rom_present && in_rom_area)
                    item.cls = CLS_PRG_ROM;
                else if (cfg.prg_ram_present && ram_window)
                    item.cls = CLS_RAM_RD;
            end
            KIND_CPU_WR:
            begin
                if (in_rom_area)
                    item.cls = CLS_REG_WR;
                else if (cfg.prg_ram_present && ram_window)
                    item.cls = CLS_RAM_WR;
            end
            KIND_PPU_RD: item.cls = CLS_CHR_RD;
            KIND_PPU_WR: item.cls = CLS_CHR_WR;
            default:     item.cls = CLS_NONE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sbm_queue.sv
`default_nettype none

module sbm_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push_valid,
    input  sbm_pkg::queue_item_t push_item,
    output logic                 full,
    output logic                 head_valid,
    output sbm_pkg::queue_item_t head_item,
    input  wire                  pop
);
    import sbm_pkg::*;

    queue_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop_ok;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !full;
    assign pop_ok     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        if (pop_ok)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        if (push && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (pop_ok && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/sbm_back.sv
`default_nettype none

module sbm_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  sbm_pkg::cfg_t        cfg,
    input  wire                  head_valid,
    input  sbm_pkg::queue_item_t head_item,
    output logic                 pop,
    output logic                 rsp_valid,
    output sbm_pkg::rsp_t        rsp,
    input  wire                  rsp_stall
);
    import sbm_pkg::*;

    logic [4:0]  shift_reg, shift_next;
    logic [2:0]  bits_loaded_reg, bits_loaded_next;
    logic [4:0]  control_reg, control_next;
    logic [4:0]  chr_low_reg, chr_low_next;
    logic [4:0]  chr_high_reg, chr_high_next;
    logic [4:0]  prg_select_reg, prg_select_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg;

    logic [15:0] addr;
    logic [3:0]  prg_bank;
    logic [7:0]  last_bank;
    logic [21:0] prg_map;
    logic        prg_hit;
    logic [16:0] chr_map;
    logic        chr_fits;
    logic [4:0]  shifted;
    rsp_t        result;

    assign pop       = head_valid && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign addr      = head_item.bus_address;
    assign prg_bank  = prg_select_reg[3:0];
    assign last_bank = cfg.prg_banks - 8'd1;

    always_comb
    begin
        case (control_reg[3:2])
            PRG_MODE_32K_A, PRG_MODE_32K_B:
                prg_map = {4'b0, prg_bank[3:1], addr[14:0]};
            PRG_MODE_FIX_FIRST:
                prg_map = addr[14] ? {4'b0, prg_bank, addr[13:0]}
                                   : {8'b0, addr[13:0]};
            default:
                prg_map = addr[14] ? {last_bank, addr[13:0]}
                                   : {4'b0, prg_bank, addr[13:0]};
        endcase
    end

    // ROM holds bank_count * 16KB
    assign prg_hit = (prg_map < {cfg.prg_banks, 14'b0});

    always_comb
    begin
        if (!control_reg[4])
            chr_map = {chr_low_reg[4:1], addr[12:0]};
        else if (addr[15:12] == 4'd0)
            chr_map = {chr_low_reg, addr[11:0]};
        else
            chr_map = {chr_high_reg, addr[11:0]};
    end

    assign chr_fits = ({1'b0, chr_map} < cfg.chr_size_bytes);

    always_comb
    begin
        result.target      = TGT_NONE;
        result.mem_address = '0;
        case (head_item.cls)
            CLS_PRG_ROM:
            begin
                if (prg_hit)
                begin
                    result.target      = TGT_PRG_ROM_RD;
                    result.mem_address = prg_map;
                end
            end
            CLS_RAM_RD:
            begin
                result.target      = TGT_PRG_RAM_RD;
                result.mem_address = {9'b0, head_item.ram_offset};
            end
            CLS_RAM_WR:
            begin
                result.target      = TGT_PRG_RAM_WR;
                result.mem_address = {9'b0, head_item.ram_offset};
            end
            CLS_REG_WR:
                result.target = TGT_REG_WR;
            CLS_CHR_RD:
            begin
                if (cfg.chr_rom_present && chr_fits)
                begin
                    result.target      = TGT_CHR_ROM_RD;
                    result.mem_address = {5'b0, chr_map};
                end
                else if (cfg.chr_ram_present && chr_fits)
                begin
                    result.target      = TGT_CHR_RAM_RD;
                    result.mem_address = {5'b0, chr_map};
                end
            end
            CLS_CHR_WR:
            begin
                if (cfg.chr_ram_present && chr_fits)
                begin
                    result.target      = TGT_CHR_RAM_WR;
                    result.mem_address = {5'b0, chr_map};
                end
            end
            default:
            begin
                result.target      = TGT_NONE;
                result.mem_address = '0;
            end
        endcase
    end

    assign shifted = {head_item.load_bit, shift_reg[4:1]};

    // serial loader
    always_comb
    begin
        shift_next       = shift_reg;
        bits_loaded_next = bits_loaded_reg;
        control_next     = control_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        prg_select_next  = prg_select_reg;
        if (pop && (head_item.cls == CLS_REG_WR))
        begin
            if (head_item.load_reset)
            begin
                shift_next       = SHIFT_RESET;
                bits_loaded_next = '0;
                control_next     = control_reg | CONTROL_RESET;
            end
            else if (bits_loaded_reg == LOAD_LAST)
            begin
                shift_next       = SHIFT_RESET;
                bits_loaded_next = '0;
                case (addr[14:13])
                    DEST_CONTROL:  control_next    = shifted;
                    DEST_CHR_LOW:  chr_low_next    = shifted;
                    DEST_CHR_HIGH: chr_high_next   = shifted;
                    DEST_PRG:      prg_select_next = shifted;
                    default:       prg_select_next = shifted;
                endcase
            end
            else
            begin
                shift_next       = shifted;
                bits_loaded_next = bits_loaded_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (pop)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg       <= SHIFT_RESET;
            bits_loaded_reg <= '0;
            control_reg     <= CONTROL_RESET;
            chr_low_reg     <= '0;
            chr_high_reg    <= '0;
            prg_select_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            shift_reg       <= shift_next;
            bits_loaded_reg <= bits_loaded_next;
            control_reg     <= control_next;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            prg_select_reg  <= prg_select_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_reg <= result;
    end

    a_loader_count: assert property (@(posedge clk) disable iff (!rst_n)
        bits_loaded_reg <= LOAD_LAST)
        else $error("serial loader count out of range");

    a_loader_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (head_item.cls == CLS_REG_WR) && head_item.load_reset)
        |=> (control_reg[3:2] == 2'b11) && (bits_loaded_reg == 3'd0))
        else $error("loader reset did not force fixed-last PRG mode");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && ((rsp_reg.target == TGT_NONE) || (rsp_reg.target == TGT_REG_WR)))
        |-> (rsp_reg.mem_address == 22'd0))
        else $error("nonzero address on an unmapped or register result");

endmodule

`default_nettype wire

>>> rtl/serial_bank_mapper.sv
// Serial bank mapper: translates one CPU or PPU bus access per transfer.
// Request channel: req_valid / req_stall carry req (kind, bus_address,
// write_byte). Response channel: rsp_valid / rsp_stall carry rsp (target,
// mem_address). Each request gives exactly one response, in order.
// A request is written into a queue entry; the back end then registers its
// result in the response register that drives rsp_valid.
// Throughput: one access per cycle while rsp_stall is low. The front end
// classifies the access into a two-entry queue; the back end applies bank
// registers and the serial loader and registers the result, so a new
// request is taken while a finished response waits.
// When the receiver stalls, the held response stays in place, the queue
// fills and req_stall rises once both queue entries are occupied.
// Configuration: cfg_write, cfg_index, cfg_data write one register per
// cycle; write only while no request is in flight. Unknown indexes are ignored.
// Reset (rst_n low, asynchronous) empties the queue, drops rsp_valid,
// reloads the bank registers (control 0x0C, loader empty) and restores the
// configuration defaults: 2 PRG banks, PRG ROM and RAM present, 8KB RAM,
// 8KB CHR ROM.
`default_nettype none

module serial_bank_mapper (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   req_valid,
    output logic                                  req_stall,
    input  sbm_pkg::req_t                         req,
    output logic                                  rsp_valid,
    input  wire                                   rsp_stall,
    output sbm_pkg::rsp_t                         rsp,
    input  wire                                   cfg_write,
    input  wire [sbm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire [sbm_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import sbm_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    queue_item_t front_item;
    queue_item_t head_item;
    logic        queue_full;
    logic        head_valid;
    logic        pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PRG_BANKS:         cfg_next.prg_banks         = cfg_data[7:0];
                REG_PRG_ROM_PRESENT:   cfg_next.prg_rom_present   = cfg_data[0];
                REG_PRG_RAM_PRESENT:   cfg_next.prg_ram_present   = cfg_data[0];
                REG_PRG_RAM_SIZE_LOG2: cfg_next.prg_ram_size_log2 = cfg_data[3:0];
                REG_CHR_ROM_PRESENT:   cfg_next.chr_rom_present   = cfg_data[0];
                REG_CHR_RAM_PRESENT:   cfg_next.chr_ram_present   = cfg_data[0];
                REG_CHR_SIZE_BYTES:    cfg_next.chr_size_bytes    = cfg_data[17:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_banks         <= 8'd2;
            cfg_reg.prg_rom_present   <= 1'b1;
            cfg_reg.prg_ram_present   <= 1'b1;
            cfg_reg.prg_ram_size_log2 <= 4'd13;
            cfg_reg.chr_rom_present   <= 1'b1;
            cfg_reg.chr_ram_present   <= 1'b0;
            cfg_reg.chr_size_bytes    <= 18'd8192;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign req_stall = queue_full;

    sbm_front u_front (
        .req  (req),
        .cfg  (cfg_reg),
        .item (front_item)
    );

    sbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_item  (front_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    sbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .rsp_stall  (rsp_stall)
    );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import sbm_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    localparam int SETTLE_LAT   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int LOAD_BITS    = 5;

    // index past the last register, must be ignored by the block
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    serial_bank_mapper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // mirror of the mapper state
    cfg_t       map_cfg;
    logic [4:0] ld_shift;
    logic [2:0] ld_count;
    logic [4:0] ctrl_reg;
    logic [4:0] chr_bank_lo;
    logic [4:0] chr_bank_hi;
    logic [4:0] prg_bank_sel;

    rsp_t expected_rsp_q[$];
    int   error_count     = 0;
    int   cycle_count     = 0;
    int   hold_until      = 0;
    int   send_idle_pct   = 0;
    int   recv_idle_pct   = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (cycle_count < hold_until)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
                note_error($sformatf("unexpected transfer target %0d addr 0x%06h",
                                     rsp.target, rsp.mem_address));
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.target !== want.target)
                    note_error($sformatf("target expected %0d actual %0d",
                                         want.target, rsp.target));
                if (rsp.mem_address !== want.mem_address)
                    note_error($sformatf("mem_address expected 0x%06h actual 0x%06h",
                                         want.mem_address, rsp.mem_address));
            end
        end
    end

    function automatic rsp_t map_access(input req_t a);
        rsp_t        r;
        int unsigned addr;
        int unsigned m;
        int unsigned bank;
        int unsigned last_bank;
        int unsigned lg;
        logic        in_ram;
        logic        fits;
        r      = '0;
        addr   = a.bus_address;
        in_ram = (addr >= RAM_WINDOW_BASE) && (addr < ROM_BASE);
        case (a.kind)
            KIND_CPU_RD:
            begin
                if (map_cfg.prg_rom_present && addr >= ROM_BASE)
                begin
                    bank      = prg_bank_sel & 5'h0F;
                    last_bank = (int'(map_cfg.prg_banks) - 1) & 32'hFF;
                    if (ctrl_reg[3:2] == PRG_MODE_32K_A || ctrl_reg[3:2] == PRG_MODE_32K_B)
                        m = (bank & 32'h0E) * 32'h4000 + (addr & 32'h7FFF);
                    else if (ctrl_reg[3:2] == PRG_MODE_FIX_FIRST)
                        m = (addr < 32'hC000) ? (addr & 32'h3FFF)
                                              : bank * 32'h4000 + (addr & 32'h3FFF);
                    else
                        m = (addr < 32'hC000) ? bank * 32'h4000 + (addr & 32'h3FFF)
                                              : last_bank * 32'h4000 + (addr & 32'h3FFF);
                    if (m < int'(map_cfg.prg_banks) * 32'h4000)
                    begin
                        r.target      = TGT_PRG_ROM_RD;
                        r.mem_address = m[21:0];
                    end
                end
                else if (map_cfg.prg_ram_present && in_ram)
                begin
                    lg            = (map_cfg.prg_ram_size_log2 > RAM_LOG2_MAX) ? RAM_LOG2_MAX
                                                                    : map_cfg.prg_ram_size_log2;
                    m             = (addr - RAM_WINDOW_BASE) & ((32'd1 << lg) - 1);
                    r.target      = TGT_PRG_RAM_RD;
                    r.mem_address = m[21:0];
                end
            end
            KIND_CPU_WR:
            begin
                if (addr >= ROM_BASE)
                begin
                    if (a.write_byte[7])
                    begin
                        ld_shift = SHIFT_RESET;
                        ctrl_reg = ctrl_reg | CONTROL_RESET;
                        ld_count = '0;
                    end
                    else
                    begin
                        ld_shift = {a.write_byte[0], ld_shift[4:1]};
                        ld_count = ld_count + 3'd1;
                        if (ld_count == LOAD_BITS)
                        begin
                            case (a.bus_address[14:13])
                                DEST_CONTROL:  ctrl_reg     = ld_shift;
                                DEST_CHR_LOW:  chr_bank_lo  = ld_shift;
                                DEST_CHR_HIGH: chr_bank_hi  = ld_shift;
                                default:       prg_bank_sel = ld_shift;
                            endcase
                            ld_shift = SHIFT_RESET;
                            ld_count = '0;
                        end
                    end
                    r.target = TGT_REG_WR;
                end
                else if (map_cfg.prg_ram_present && in_ram)
                begin
                    lg            = (map_cfg.prg_ram_size_log2 > RAM_LOG2_MAX) ? RAM_LOG2_MAX
                                                                    : map_cfg.prg_ram_size_log2;
                    m             = (addr - RAM_WINDOW_BASE) & ((32'd1 << lg) - 1);
                    r.target      = TGT_PRG_RAM_WR;
                    r.mem_address = m[21:0];
                end
            end
            default:
            begin
                if (!ctrl_reg[4])
                    m = (chr_bank_lo & 5'h1E) * 32'h1000 + (addr & 32'h1FFF);
                else if (addr < 32'h1000)
                    m = chr_bank_lo * 32'h1000 + (addr & 32'h0FFF);
                else
                    m = chr_bank_hi * 32'h1000 + (addr & 32'h0FFF);
                fits = (m < map_cfg.chr_size_bytes);
                if (a.kind == KIND_PPU_RD)
                begin
                    if (map_cfg.chr_rom_present && fits)
                        r.target = TGT_CHR_ROM_RD;
                    else if (map_cfg.chr_ram_present && fits)
                        r.target = TGT_CHR_RAM_RD;
                end
                else if (map_cfg.chr_ram_present && fits)
                    r.target = TGT_CHR_RAM_WR;
                if (r.target != TGT_NONE)
                    r.mem_address = m[21:0];
            end
        endcase
        return r;
    endfunction

    // one transfer on the request channel, with a random gap in front
    task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [7:0] data);
        req_t item;
        int   gap;
        item.kind        = kind;
        item.bus_address = addr;
        item.write_byte  = data;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp_q.push_back(map_access(item));
    endtask

    task automatic drain_pipeline();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LAT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PRG_BANKS:         map_cfg.prg_banks         = data[7:0];
            REG_PRG_ROM_PRESENT:   map_cfg.prg_rom_present   = data[0];
            REG_PRG_RAM_PRESENT:   map_cfg.prg_ram_present   = data[0];
            REG_PRG_RAM_SIZE_LOG2: map_cfg.prg_ram_size_log2 = data[3:0];
            REG_CHR_ROM_PRESENT:   map_cfg.chr_rom_present   = data[0];
            REG_CHR_RAM_PRESENT:   map_cfg.chr_ram_present   = data[0];
            REG_CHR_SIZE_BYTES:    map_cfg.chr_size_bytes    = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        drain_pipeline();
        write_reg(REG_PRG_BANKS,         CFG_DATA_W'(c.prg_banks));
        write_reg(REG_PRG_ROM_PRESENT,   CFG_DATA_W'(c.prg_rom_present));
        write_reg(REG_PRG_RAM_PRESENT,   CFG_DATA_W'(c.prg_ram_present));
        write_reg(REG_PRG_RAM_SIZE_LOG2, CFG_DATA_W'(c.prg_ram_size_log2));
        write_reg(REG_CHR_ROM_PRESENT,   CFG_DATA_W'(c.chr_rom_present));
        write_reg(REG_CHR_RAM_PRESENT,   CFG_DATA_W'(c.chr_ram_present));
        write_reg(REG_CHR_SIZE_BYTES,    c.chr_size_bytes);
        write_reg(REG_UNUSED,            CFG_DATA_W'($urandom()));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cfg_t make_config(input int count, input bit rom, input bit ram,
                                         input int ram_log2, input bit chr_rom,
                                         input bit chr_ram, input int chr_size);
        cfg_t c;
        c.prg_banks         = count[7:0];
        c.prg_rom_present   = rom;
        c.prg_ram_present   = ram;
        c.prg_ram_size_log2 = ram_log2[3:0];
        c.chr_rom_present   = chr_rom;
        c.chr_ram_present   = chr_ram;
        c.chr_size_bytes    = chr_size[17:0];
        return c;
    endfunction

    function automatic cfg_t random_config();
        int count;
        int chr_size;
        case ($urandom_range(0, 3))
            0:       count = $urandom_range(0, 255);
            1:       count = 16;
            2:       count = 32;
            default: count = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 3))
            0:       chr_size = $urandom_range(0, 262143);
            1:       chr_size = 131072;
            2:       chr_size = 65536;
            default: chr_size = 8192;
        endcase
        return make_config(count, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                           $urandom_range(0, 15), $urandom_range(0, 1) != 0,
                           $urandom_range(0, 2) != 0, chr_size);
    endfunction

    // one random access, or a serial register load of five writes, sometimes after a loader reset write
    task automatic send_random_traffic(output int n_sent);
        int          pick;
        int          brk;
        logic [1:0]  dest;
        logic [1:0]  kind;
        logic [15:0] addr;
        pick   = $urandom_range(0, 99);
        n_sent = 1;
        if (pick < 30)
        begin
            n_sent = 0;
            if ($urandom_range(0, 3) == 0)
            begin
                send_access(KIND_CPU_WR, ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
                            8'h80 | 8'($urandom_range(0, 127)));
                n_sent++;
            end
            dest = 2'($urandom_range(0, 3));
            // now and then a loader reset lands on one of the writes of a load
            brk  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LOAD_BITS - 1) : -1;
            for (int i = 0; i < LOAD_BITS; i++)
            begin
                addr = {1'b1, dest, 13'($urandom_range(0, 16'h1FFF))};
                if (i == brk)
                    send_access(KIND_CPU_WR, addr, 8'h80 | 8'($urandom_range(0, 127)));
                else
                    send_access(KIND_CPU_WR, addr, 8'($urandom_range(0, 127)));
                n_sent++;
            end
        end
        else if (pick < 50)
            send_access(KIND_CPU_RD, ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
                        8'($urandom_range(0, 255)));
        else if (pick < 60)
        begin
            kind = $urandom_range(0, 1) ? KIND_CPU_WR : KIND_CPU_RD;
            send_access(kind, RAM_WINDOW_BASE | 16'($urandom_range(0, 16'h1FFF)),
                        8'($urandom_range(0, 255)));
        end
        else if (pick < 85)
        begin
            kind = $urandom_range(0, 1) ? KIND_PPU_WR : KIND_PPU_RD;
            addr = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 16'h1FFF))
                                               : 16'($urandom_range(0, 16'hFFFF));
            send_access(kind, addr, 8'($urandom_range(0, 255)));
        end
        else
            send_access(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                        8'($urandom_range(0, 255)));
    endtask

    task automatic test_reset_defaults();
        send_access(KIND_CPU_RD, 16'h8000, 8'h00);
        send_access(KIND_CPU_RD, 16'hFFFF, 8'hFF);
        send_access(KIND_CPU_RD, 16'h0000, 8'h00);
        send_access(KIND_CPU_RD, 16'h5FFF, 8'h00);
        send_access(KIND_CPU_RD, 16'h6000, 8'h00);
        send_access(KIND_CPU_WR, 16'h7FFF, 8'hFF);
        send_access(KIND_PPU_RD, 16'h0000, 8'h00);
        send_access(KIND_PPU_RD, 16'h3FFF, 8'h00);
        send_access(KIND_PPU_WR, 16'h1000, 8'h00);
        send_access(KIND_CPU_WR, 16'h8000, 8'h80);
        // load 0x1F into the PRG bank; the next ROM read falls outside two banks
        for (int i = 0; i < LOAD_BITS; i++)
            send_access(KIND_CPU_WR, 16'hE000, 8'h7F);
        send_access(KIND_CPU_RD, 16'h8000, 8'h00);
    endtask

    task automatic test_absent_memories();
        apply_config(make_config(0, 1'b1, 1'b0, 15, 1'b0, 1'b1, 131072));
        send_access(KIND_CPU_RD, 16'h8000, 8'h00);
        send_access(KIND_CPU_WR, 16'hC000, 8'h01);
        send_access(KIND_CPU_RD, 16'h6000, 8'h00);
        send_access(KIND_CPU_WR, 16'h6000, 8'h00);
        send_access(KIND_PPU_RD, 16'h0FFF, 8'h00);
        send_access(KIND_PPU_WR, 16'h2000, 8'h00);
        send_access(KIND_PPU_RD, 16'hFFFF, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items, input cfg_t setting);
        int sent;
        int k;
        apply_config(setting);
        sent = 0;
        while (sent < n_items)
        begin
            send_random_traffic(k);
            sent += k;
        end
    endtask

    task automatic test_backpressure();
        int k;
        apply_config(random_config());
        // receiver holds off so the queue fills and the input stalls
        hold_until = cycle_count + HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_random_traffic(k);
        drain_pipeline();
        hold_until = cycle_count + HOLD_CYCLES;
        for (int i = 0; i < 20; i++)
            send_random_traffic(k);
    endtask

    initial
    begin
        map_cfg      = make_config(2, 1'b1, 1'b1, 13, 1'b1, 1'b0, 8192);
        ld_shift     = SHIFT_RESET;
        ld_count     = '0;
        ctrl_reg     = CONTROL_RESET;
        chr_bank_lo  = '0;
        chr_bank_hi  = '0;
        prg_bank_sel = '0;

        send_idle_pct = 10;
        recv_idle_pct = 65;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_absent_memories();
        test_random_traffic(150, random_config());
        test_random_traffic(120, make_config(255, 1'b1, 1'b1, 15, 1'b1, 1'b1, 262143));

        send_idle_pct = 65;
        recv_idle_pct = 10;
        test_random_traffic(150, random_config());
        test_random_traffic(60, make_config(0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 0));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120, random_config());
        test_backpressure();

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
